// File: src/bb3_pkg.sv
// bb3_pkg: shared types, codes and constants of the 3x3 rgba box blur
// no dependencies; imported by every module of the block
`default_nettype none

package bb3_pkg;

    localparam int PIX_W        = 8;
    localparam int TDATA_W      = 32;
    localparam int NUM_CELLS    = 9;
    localparam int NUM_LANES    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int COL_SUM_W    = 10;
    localparam int SUM_W        = 12;
    localparam int RECIP_W      = 14;
    localparam int RECIP_SHIFT  = 15;

    // sum * recip >> 15 gives the exact truncated quotient for sums below 2296
    localparam logic [RECIP_W-1:0] RECIP_BY_4 = 14'd8192;
    localparam logic [RECIP_W-1:0] RECIP_BY_6 = 14'd5462;
    localparam logic [RECIP_W-1:0] RECIP_BY_9 = 14'd3641;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        DIV_BY_4 = 2'd0,
        DIV_BY_6 = 2'd1,
        DIV_BY_9 = 2'd2
    } div_sel_t;

    // which neighbors of the output pixel lie inside the image
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } nbr_flags_t;

    typedef logic [TDATA_W-1:0] pixel_t;

    // cell index is column * 3 + row, column 0 oldest, row 0 topmost
    function automatic logic [NUM_CELLS-1:0] keep_mask(nbr_flags_t f);
        logic [NUM_CELLS-1:0] m;
        logic col_ok;
        logic row_ok;
        m = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                col_ok = (c == 0) ? f.left : ((c == 2) ? f.right : 1'b1);
                row_ok = (r == 0) ? f.top : ((r == 2) ? f.bottom : 1'b1);
                m[c*3+r] = col_ok & row_ok;
            end
        end
        return m;
    endfunction

    function automatic div_sel_t div_select(nbr_flags_t f);
        div_sel_t d;
        if (f.top && f.bottom && f.left && f.right) begin
            d = DIV_BY_9;
        end else if ((f.top && f.bottom) || (f.left && f.right)) begin
            d = DIV_BY_6;
        end else begin
            d = DIV_BY_4;
        end
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(div_sel_t d);
        logic [RECIP_W-1:0] r;
        case (d)
            DIV_BY_4: r = RECIP_BY_4;
            DIV_BY_6: r = RECIP_BY_6;
            DIV_BY_9: r = RECIP_BY_9;
            default:  r = RECIP_BY_9;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/bb3_line_store.sv
// bb3_line_store: the two row buffers of the blur window, one entry per column
// depends on bb3_pkg; read data registered, the upper row is refilled from the lower
`default_nettype none

module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire pixel_t            wr_pix,
    output      pixel_t            upper_rd,
    output      pixel_t            lower_rd
);

    pixel_t upper_mem [DEPTH];
    pixel_t lower_mem [DEPTH];
    pixel_t upper_rd_reg;
    pixel_t lower_rd_reg;

    // the column read for an item is written back when that item moves on
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr] <= lower_rd_reg;
        end
        if (rd_en) begin
            upper_rd_reg <= upper_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lower_mem[wr_addr] <= wr_pix;
        end
        if (rd_en) begin
            lower_rd_reg <= lower_mem[rd_addr];
        end
    end

    assign upper_rd = upper_rd_reg;
    assign lower_rd = lower_rd_reg;

endmodule

`default_nettype wire

// File: src/bb3_lane.sv
// bb3_lane: one color channel, masked sum of the window and division by 4, 6 or 9
// depends on bb3_pkg; registered sum, then one reciprocal multiply
`default_nettype none

module bb3_lane
    import bb3_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 load,
    input  wire logic [PIX_W-1:0]     cell_bytes [NUM_CELLS],
    input  wire logic [NUM_CELLS-1:0] keep,
    input  wire div_sel_t             div_sel,
    output      logic [PIX_W-1:0]     quotient
);

    logic [COL_SUM_W-1:0]     col_sum [3];
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W-1:0]         sum_reg;
    div_sel_t                 div_reg;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            col_sum[c] = '0;
            for (int r = 0; r < 3; r++) begin
                if (keep[c*3+r]) begin
                    col_sum[c] = col_sum[c] + COL_SUM_W'(cell_bytes[c*3+r]);
                end
            end
        end
        sum_next = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= sum_next;
            div_reg <= div_sel;
        end
    end

    assign prod     = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(recip_of(div_reg));
    assign quotient = prod[RECIP_SHIFT +: PIX_W];

endmodule

`default_nettype wire

// File: src/box_blur_3x3_rgba_unit.sv
// box_blur_3x3_rgba_unit: 3x3 mean filter on a raster-order rgba pixel stream
// depends on bb3_pkg, bb3_line_store and bb3_lane
//
// usage
//  - input beats carry one rgba pixel each (s_tuser = 0) or a flush tick (s_tuser = 1)
//  - each output beat is one filtered pixel: red, green and blue are the truncated
//    mean of the 3x3 neighborhood clipped to the image, alpha is the center alpha
//  - m_tlast marks the last output pixel of a frame, after which a new frame starts
//  - output for a pixel comes once the pixel one row plus one column later has been
//    seen; after the last pixel send width + 1 flush beats to drain the frame
//  - flush beats sent while the frame still expects pixels, and pixels sent while it
//    is draining, are taken and dropped
//  - throughput one beat per clock unless m_tready stalls, limited by the single read
//    port of the line stores (one column per cycle); an output beat passes stages 1-3
//    and the output register after the input beat that completes its window
//  - a write to image_width or image_height restarts the frame; sizes are clamped
//    to 2 .. MAX_WIDTH and 2 .. MAX_HEIGHT; write only while the block is idle
//  - reset (aresetn low, synchronous) empties the pipeline and restarts the frame;
//    the line stores need no clearing pass, unwritten entries are always masked
//  - when m_tready is low the output beat holds; bubbles in the pipeline still fill,
//    so s_tready drops only once all stages hold live data
`default_nettype none

module box_blur_3x3_rgba_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  wire logic [0:0]            s_tuser,   // command
    // output stream
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [TDATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out, alpha_out
    output      logic                  m_tlast    // frame_end
);

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);
    localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RESET_HEIGHT = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // ---------------- frame size registers ----------------
    logic [COL_W-1:0]        wm1_reg, wm1_next;     // width - 1
    logic [ROW_W-1:0]        h_reg, h_next;         // height
    logic [ROW_W-1:0]        hm1_reg, hm1_next;     // height - 1
    logic [WIDTH_REG_W-1:0]  cfg_width;
    logic [HEIGHT_REG_W-1:0] cfg_height;
    logic                    cfg_restart;

    // ---------------- positions ----------------
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    // ---------------- pipeline ----------------
    command_t         cmd;
    logic             accept;
    logic             in_done;
    logic             item_active;
    logic             in_emit;
    logic             take;
    nbr_flags_t       flags;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    nbr_flags_t       s1_flags_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_go;
    logic             shift;

    pixel_t                 window_reg [NUM_CELLS];
    logic                   s2_valid_reg;
    logic [NUM_CELLS-1:0]   s2_keep_reg;
    div_sel_t               s2_div_reg;
    logic                   s2_last_reg;
    logic                   s2_go;

    logic                   s3_valid_reg;
    logic                   s3_last_reg;
    logic [PIX_W-1:0]       s3_alpha_reg;
    logic                   s3_go;

    logic                   m_valid_reg;
    logic [TDATA_W-1:0]     m_data_reg;
    logic                   m_last_reg;

    pixel_t                 upper_rd;
    pixel_t                 lower_rd;
    logic [PIX_W-1:0]       lane_cells [NUM_LANES][NUM_CELLS];
    logic [PIX_W-1:0]       lane_q [NUM_LANES];

    // ---------------- configuration ----------------
    assign cfg_width  = cfg_wr_data[WIDTH_REG_W-1:0];
    assign cfg_height = cfg_wr_data[HEIGHT_REG_W-1:0];

    always_comb begin
        wm1_next    = wm1_reg;
        h_next      = h_reg;
        cfg_restart = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_IMAGE_WIDTH: begin
                    cfg_restart = 1'b1;
                    if (cfg_width < WIDTH_REG_W'(2)) begin
                        wm1_next = COL_W'(1);
                    end else if (32'(cfg_width) > MAX_WIDTH) begin
                        wm1_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        wm1_next = COL_W'(cfg_width - WIDTH_REG_W'(1));
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    cfg_restart = 1'b1;
                    if (cfg_height < HEIGHT_REG_W'(2)) begin
                        h_next = ROW_W'(2);
                    end else if (32'(cfg_height) > MAX_HEIGHT) begin
                        h_next = ROW_W'(MAX_HEIGHT);
                    end else begin
                        h_next = ROW_W'(cfg_height);
                    end
                end
                default: begin
                    cfg_restart = 1'b0;   // writes beyond the register list are dropped
                end
            endcase
        end
        hm1_next = h_next - ROW_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg <= COL_W'(RESET_WIDTH - 1);
            h_reg   <= ROW_W'(RESET_HEIGHT);
            hm1_reg <= ROW_W'(RESET_HEIGHT - 1);
        end else begin
            wm1_reg <= wm1_next;
            h_reg   <= h_next;
            hm1_reg <= hm1_next;
        end
    end

    // ---------------- stage 0: classify the beat, advance positions ----------------
    assign cmd         = command_t'(s_tuser[0]);
    assign accept      = s_tvalid && s_tready;
    assign in_done     = in_row_reg >= h_reg;
    // pixels count only while the frame expects them, flushes only after
    assign item_active = (cmd == CMD_FLUSH) ? in_done : !in_done;
    assign take        = accept && item_active;
    // first output once one row plus one pixel are in
    assign in_emit     = (in_row_reg >= ROW_W'(2)) ||
                         ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    assign flags.top    = out_row_reg != '0;
    assign flags.bottom = out_row_reg != hm1_reg;
    assign flags.left   = out_col_reg != '0;
    assign flags.right  = out_col_reg != wm1_reg;
    assign flags.last   = !flags.bottom && !flags.right;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (take) begin
            if (in_emit && flags.last) begin
                // frame done, everything back to the top left corner
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (in_col_reg == wm1_reg) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (in_emit) begin
                    if (out_col_reg == wm1_reg) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- stall chain ----------------
    assign s3_go    = !m_valid_reg || m_tready;
    assign s2_go    = !s3_valid_reg || s3_go;
    assign s1_go    = !s2_valid_reg || s2_go;
    assign s_tready = !s1_valid_reg || s1_go;
    assign shift    = s1_valid_reg && s1_go;

    // ---------------- stage 1: line store read ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg  <= in_emit;
            s1_flags_reg <= flags;
            s1_pix_reg   <= (cmd == CMD_FLUSH) ? '0 : s_tdata;
            s1_col_reg   <= in_col_reg;
        end
    end

    bb3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_addr  (in_col_reg),
        .wr_en    (shift),
        .wr_addr  (s1_col_reg),
        .wr_pix   (s1_pix_reg),
        .upper_rd (upper_rd),
        .lower_rd (lower_rd)
    );

    // ---------------- stage 2: window shift ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    // every live beat shifts the window, emitting or not
    always_ff @(posedge aclk) begin
        if (shift) begin
            for (int k = 0; k < NUM_CELLS - 3; k++) begin
                window_reg[k] <= window_reg[k+3];
            end
            window_reg[NUM_CELLS-3] <= upper_rd;
            window_reg[NUM_CELLS-2] <= lower_rd;
            window_reg[NUM_CELLS-1] <= s1_pix_reg;
            s2_keep_reg             <= keep_mask(s1_flags_reg);
            s2_div_reg              <= div_select(s1_flags_reg);
            s2_last_reg             <= s1_flags_reg.last;
        end
    end

    // ---------------- stage 3: one lane per color ----------------
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            for (int k = 0; k < NUM_CELLS; k++) begin
                lane_cells[l][k] = window_reg[k][l*PIX_W +: PIX_W];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        bb3_lane u_lane (
            .aclk       (aclk),
            .load       (s2_go),
            .cell_bytes (lane_cells[l]),
            .keep       (s2_keep_reg),
            .div_sel    (s2_div_reg),
            .quotient   (lane_q[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s2_go) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // alpha comes straight from the center cell
    always_ff @(posedge aclk) begin
        if (s2_go) begin
            s3_alpha_reg <= window_reg[4][3*PIX_W +: PIX_W];
            s3_last_reg  <= s2_last_reg;
        end
    end

    // ---------------- output register: merge the lanes ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_go) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_go) begin
            m_data_reg <= {s3_alpha_reg, lane_q[2], lane_q[1], lane_q[0]};
            m_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: src/bb3_checker.sv
// bb3_checker: port-level assertions for box_blur_3x3_rgba_unit, bound to the top level
// depends on bb3_pkg and box_blur_3x3_rgba_unit
`default_nettype none

module bb3_checker
    import bb3_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tlast
);

    // an empty or draining output stage lets the whole pipeline move
    a_ready_when_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage was free");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed under stall");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // no beat can cross the four pipeline stages sooner
    a_fill_latency: assert property (@(posedge aclk)
        $rose(aresetn) |-> (!m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid))
        else $error("output beat earlier than pipeline depth after reset");

    // s_tvalid is part of the watched port set, kept for stall context in waves
    a_tvalid_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !$isunknown(s_tready))
        else $error("unknown ready on input beat");

endmodule

bind box_blur_3x3_rgba_unit bb3_checker u_bb3_checker (.*);

`default_nettype wire
